// ===== design/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and codes for the time-of-day clock with alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

   // width of one time field (hour, minute or second)
   localparam int unsigned FIELD_W = 7;
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned MODE_W  = 2;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_12H   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_24H   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_ALARM = 3'd3;
   localparam logic [CMD_W-1:0] CMD_START     = 3'd4;

   // hour mode codes
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_12H  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_24H  = 2'd2;

   // field limits
   localparam logic [FIELD_W-1:0] SEC_MAX  = 7'd59;
   localparam logic [FIELD_W-1:0] MIN_MAX  = 7'd59;
   localparam logic [FIELD_W-1:0] HOUR_12  = 7'd12;
   localparam logic [FIELD_W-1:0] HOUR_23  = 7'd23;
   localparam logic [FIELD_W-1:0] HOUR_ONE = 7'd1;

   // one request
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [FIELD_W-1:0] hour_value;
      logic [FIELD_W-1:0] minute_value;
      logic [FIELD_W-1:0] second_value;
   } tdc_item_type;

   // one response
   typedef struct packed {
      logic [FIELD_W-1:0] cur_hour;
      logic [FIELD_W-1:0] cur_minute;
      logic [FIELD_W-1:0] cur_second;
      logic               clock_running;
      logic               led_pin_level;
   } tdc_result_type;

endpackage

`default_nettype wire

// ===== design/time_of_day_clock_with_alarm.sv =====
// ----------------------------------------------------------------------------
// time_of_day_clock_with_alarm
// Hours-minutes-seconds clock with 12h/24h modes and a one-shot alarm that
// toggles an LED level on every later tick.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+---------------------------------
//   req_    | in        | req_valid/stall   | cmd, hour/minute/second value
//   rsp_    | out       | rsp_valid/stall   | cur time, running, LED level
//
// One request per cycle sustained while the response side does not stall; each
// request passes the input register, then the response register.
// The state update is one pass of compare/increment logic in the time keeper.
// Reset is synchronous: time, alarm and mode clear, the LED level goes high.
// A stalled response holds; the input register still drains into the
// response register in the same cycle the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_clock_with_alarm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [tdc_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [tdc_pkg::FIELD_W-1:0]   req_hour_value,
   input  wire logic [tdc_pkg::FIELD_W-1:0]   req_minute_value,
   input  wire logic [tdc_pkg::FIELD_W-1:0]   req_second_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [tdc_pkg::FIELD_W-1:0]   rsp_cur_hour,
   output      logic [tdc_pkg::FIELD_W-1:0]   rsp_cur_minute,
   output      logic [tdc_pkg::FIELD_W-1:0]   rsp_cur_second,
   output      logic                          rsp_clock_running,
   output      logic                          rsp_led_pin_level
);

   logic                    in_valid_ff, in_valid_in;
   tdc_pkg::tdc_item_type   item_ff;
   logic                    out_valid_ff, out_valid_in;
   tdc_pkg::tdc_result_type result_ff;
   tdc_pkg::tdc_result_type result_next;
   logic                    accept;
   logic                    advance;

   // move the held request on when the response slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd          <= req_cmd;
         item_ff.hour_value   <= req_hour_value;
         item_ff.minute_value <= req_minute_value;
         item_ff.second_value <= req_second_value;
      end
   end

   // clock state and update
   tdc_time_keeper u_keeper (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (result_next)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_cur_hour      = result_ff.cur_hour;
   assign rsp_cur_minute    = result_ff.cur_minute;
   assign rsp_cur_second    = result_ff.cur_second;
   assign rsp_clock_running = result_ff.clock_running;
   assign rsp_led_pin_level = result_ff.led_pin_level;

   // a request taken lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted request not held in input register");

   // a processed request always yields a response next cycle
   a_advance_resp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed request produced no response");

   // an empty response slot never blocks the input side
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && in_valid_ff) |-> !req_stall)
      else $error("input stalled while response slot empty");

   // once running, the clock never stops
   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && $past(rsp_clock_running)) |-> rsp_clock_running)
      else $error("clock_running dropped");

endmodule

`default_nettype wire

// ===== design/tdc_time_keeper.sv =====
// ----------------------------------------------------------------------------
// tdc_time_keeper
// Clock, mode, start and alarm state with its one-pass update per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_time_keeper (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire tdc_pkg::tdc_item_type   item,
   output tdc_pkg::tdc_result_type      result
);

   logic [tdc_pkg::FIELD_W-1:0] hours_ff, hours_in;
   logic [tdc_pkg::FIELD_W-1:0] minutes_ff, minutes_in;
   logic [tdc_pkg::FIELD_W-1:0] seconds_ff, seconds_in;
   logic [tdc_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic                        start_ff, start_in;
   logic                        running_ff, running_in;
   logic                        armed_ff, armed_in;
   logic [tdc_pkg::FIELD_W-1:0] al_hours_ff, al_hours_in;
   logic [tdc_pkg::FIELD_W-1:0] al_minutes_ff, al_minutes_in;
   logic [tdc_pkg::FIELD_W-1:0] al_seconds_ff, al_seconds_in;
   logic                        fired_ff, fired_in;
   logic                        led_ff, led_in;

   logic                        is_tick;
   logic                        sec_wrap;
   logic                        min_wrap;
   logic [tdc_pkg::FIELD_W-1:0] hour_adv;
   logic                        match;

   assign is_tick  = (item.cmd == tdc_pkg::CMD_TICK);
   assign sec_wrap = (seconds_ff >= tdc_pkg::SEC_MAX);
   assign min_wrap = (minutes_ff >= tdc_pkg::MIN_MAX);

   // hour rollover depends on mode
   always_comb begin
      if (mode_ff == tdc_pkg::MODE_12H) begin
         hour_adv = (hours_ff >= tdc_pkg::HOUR_12) ? tdc_pkg::HOUR_ONE
                                                   : hours_ff + 7'd1;
      end else begin
         hour_adv = (hours_ff >= tdc_pkg::HOUR_23) ? '0 : hours_ff + 7'd1;
      end
   end

   // next state for the request at hand
   always_comb begin
      hours_in      = hours_ff;
      minutes_in    = minutes_ff;
      seconds_in    = seconds_ff;
      mode_in       = mode_ff;
      start_in      = start_ff;
      running_in    = running_ff;
      armed_in      = armed_ff;
      al_hours_in   = al_hours_ff;
      al_minutes_in = al_minutes_ff;
      al_seconds_in = al_seconds_ff;
      led_in        = led_ff;

      if (is_tick) begin
         // LED toggles only once the alarm fired on an earlier request
         led_in = led_ff ^ fired_ff;
         if (running_ff) begin
            if (sec_wrap) begin
               seconds_in = '0;
               if (min_wrap) begin
                  minutes_in = '0;
                  hours_in   = hour_adv;
               end else begin
                  minutes_in = minutes_ff + 7'd1;
               end
            end else begin
               seconds_in = seconds_ff + 7'd1;
            end
         end
      end else begin
         unique case (item.cmd) inside
            tdc_pkg::CMD_SET_12H, tdc_pkg::CMD_SET_24H: begin
               mode_in    = (item.cmd == tdc_pkg::CMD_SET_12H) ? tdc_pkg::MODE_12H
                                                               : tdc_pkg::MODE_24H;
               hours_in   = item.hour_value;
               minutes_in = item.minute_value;
               seconds_in = item.second_value;
            end
            tdc_pkg::CMD_SET_ALARM: begin
               armed_in      = 1'b1;
               al_hours_in   = item.hour_value;
               al_minutes_in = item.minute_value;
               al_seconds_in = item.second_value;
            end
            tdc_pkg::CMD_START: begin
               start_in = 1'b1;
            end
            default: begin
               // unused codes leave stored values alone
            end
         endcase
         if ((mode_in != tdc_pkg::MODE_NONE) && start_in) begin
            running_in = 1'b1;
         end
      end
   end

   // alarm check on the updated time, latches once
   assign match = armed_in
                  && (hours_in == al_hours_in)
                  && (minutes_in == al_minutes_in)
                  && (seconds_in == al_seconds_in);
   assign fired_in = fired_ff | match;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff      <= '0;
         minutes_ff    <= '0;
         seconds_ff    <= '0;
         mode_ff       <= tdc_pkg::MODE_NONE;
         start_ff      <= 1'b0;
         running_ff    <= 1'b0;
         armed_ff      <= 1'b0;
         al_hours_ff   <= '0;
         al_minutes_ff <= '0;
         al_seconds_ff <= '0;
         fired_ff      <= 1'b0;
         led_ff        <= 1'b1;
      end else if (step) begin
         hours_ff      <= hours_in;
         minutes_ff    <= minutes_in;
         seconds_ff    <= seconds_in;
         mode_ff       <= mode_in;
         start_ff      <= start_in;
         running_ff    <= running_in;
         armed_ff      <= armed_in;
         al_hours_ff   <= al_hours_in;
         al_minutes_ff <= al_minutes_in;
         al_seconds_ff <= al_seconds_in;
         fired_ff      <= fired_in;
         led_ff        <= led_in;
      end
   end

   // response values after this request
   always_comb begin
      result.cur_hour      = hours_in;
      result.cur_minute    = minutes_in;
      result.cur_second    = seconds_in;
      result.clock_running = running_in;
      result.led_pin_level = led_in;
   end

endmodule

`default_nettype wire
